// File: rtl/tgl_pkg.sv
// tgl_pkg: shared constants and types for the trilinear grid lookup.
// No dependencies; imported by every module in rtl/.
package tgl_pkg;

    // Grid geometry
    localparam int SIDE_MAX    = 32;
    localparam int SIDE_W      = 6;
    localparam int CELL_W      = $clog2(SIDE_MAX);
    localparam int ADDR_W      = 3 * CELL_W;

    // Number formats
    localparam int SAMPLE_W    = 32;
    localparam int FRAC_BITS   = 12;
    localparam int POS_W       = 24;
    localparam int STEP_W      = 24;
    localparam int SUM_W       = POS_W + 1;
    localparam int PROD_SHIFT  = 32;
    localparam int COORD_SHIFT = PROD_SHIFT - FRAC_BITS;
    localparam int CIDX_W      = SUM_W + STEP_W - PROD_SHIFT;

    // Shared multiplier operands
    localparam int MUL_A_W     = SAMPLE_W + 1;
    localparam int MUL_B_W     = STEP_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 2'd2;

    // Request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } tgl_wr_t;

endpackage

// File: rtl/tgl_mul.sv
// tgl_mul: shared signed multiplier with a registered product.
// Depends on tgl_pkg for operand widths.
module tgl_mul import tgl_pkg::*; (
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/tgl_store.sv
// tgl_store: sample table with separate write and read ports, one write and one read per cycle.
// Depends on tgl_pkg for address, data widths and the write struct.
module tgl_store import tgl_pkg::*; (
    input  logic                       aclk,
    input  tgl_wr_t                    wr,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/trilinear_grid_lookup.sv
// trilinear_grid_lookup: 3-D sample table with trilinear interpolation.
// Depends on tgl_pkg, tgl_mul (shared multiplier), tgl_store (table memory).
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready   | op, pos_x/y/z, entry_index/value
//  m_      | out | m_valid / m_ready   | sample, out_of_range
//  cfg_    | in  | cfg_wr_en (no wait) | cfg_index, cfg_data
//
// A write request writes the table at the accept edge. A query uses one
// shared 33x25 multiplier for the three axis scalings, the address products
// and all seven blends in turn, and reads the eight corners from the table
// in turn; an out-of-range query skips the address products and blends.
// s_ready is high only while the sequencer is idle.
// A finished result sits in the output register; a new request is accepted
// while it waits, and the next query holds at its end until m_ready frees
// the output. aresetn (synchronous) clears the sequencer and output valid,
// sets the configuration registers to their defaults; the table is not cleared.
module trilinear_grid_lookup import tgl_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic signed [POS_W-1:0]    s_pos_x,
    input  logic signed [POS_W-1:0]    s_pos_y,
    input  logic signed [POS_W-1:0]    s_pos_z,
    input  logic [ADDR_W-1:0]          s_entry_index,
    input  logic signed [SAMPLE_W-1:0] s_entry_value,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_out_of_range
);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CELL  = 4'd1;   // scale three axes
    localparam logic [3:0] S_CHECK = 4'd2;   // range check
    localparam logic [3:0] S_ADDR  = 4'd3;   // base address products
    localparam logic [3:0] S_FIRST = 4'd4;   // read first corner
    localparam logic [3:0] S_LOAD  = 4'd5;   // corner data arrives
    localparam logic [3:0] S_MUL   = 4'd6;   // blend: diff * frac
    localparam logic [3:0] S_ACC   = 4'd7;   // blend: base + product
    localparam logic [3:0] S_OUT   = 4'd8;   // hand to output register

    localparam logic [1:0] LVL_Z = 2'd2;

    // Configuration registers
    logic signed [POS_W-1:0]    offset_reg;
    logic [STEP_W-1:0]          inv_step_reg;
    logic [SIDE_W-1:0]          side_reg;

    // Sequencer state
    logic [3:0]                 state_reg;
    logic [1:0]                 cnt_reg;
    logic [2:0]                 k_reg;
    logic [1:0]                 level_reg;

    // Query datapath
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [CIDX_W-1:0]   cell_x_reg, cell_y_reg, cell_z_reg;
    logic [FRAC_BITS-1:0]       frac_x_reg, frac_y_reg, frac_z_reg;
    logic [ADDR_W-1:0]          s2_reg, sy_reg, base_reg;
    logic signed [SAMPLE_W-1:0] hold0_reg, hold1_reg, hold2_reg;
    logic signed [SAMPLE_W:0]   diff_reg;
    logic signed [SAMPLE_W-1:0] basev_reg, res_reg;
    logic                       oor_reg;

    // Output register
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_oor_reg;

    // Shared units
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    tgl_wr_t                    wr;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [2:0]                 rd_corner;
    logic signed [SAMPLE_W-1:0] rd_data;

    // Combinational helpers
    logic                       s_fire;
    logic                       out_load;
    logic [SIDE_W-1:0]          side_eff;
    logic signed [CIDX_W-1:0]   hi;
    logic                       oor;
    logic signed [SAMPLE_W-1:0] lerp_r;
    logic                       next_bit;
    logic signed [SAMPLE_W-1:0] hold_up;
    logic [FRAC_BITS-1:0]       frac_sel;
    logic [ADDR_W-1:0]          side_a;
    logic signed [CIDX_W-1:0]   cell_new;
    logic [FRAC_BITS-1:0]       frac_new;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Result moves into the output register once that register is free
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // Effective side, saturated at SIDE_MAX; hi = side - 2 (negative below two)
    assign side_eff = (side_reg > SIDE_W'(SIDE_MAX)) ? SIDE_W'(SIDE_MAX) : side_reg;
    assign side_a   = ADDR_W'(side_eff);
    assign hi       = CIDX_W'($signed({1'b0, side_eff})) - CIDX_W'(2);

    assign oor = (cell_x_reg < 0) || (cell_y_reg < 0) || (cell_z_reg < 0) ||
                 (cell_x_reg > hi) || (cell_y_reg > hi) || (cell_z_reg > hi);

    // Axis coordinate split: cell = floor(prod / 2^32), frac = next FRAC_BITS
    assign cell_new = prod[SUM_W+STEP_W-1:PROD_SHIFT];
    assign frac_new = prod[PROD_SHIFT-1:COORD_SHIFT];

    // lerp(a,b,f) = a + floor((b-a)*f / 2^FRAC_BITS); low bits are exact
    assign lerp_r = basev_reg + prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];

    // Which input of the next level this blend result is
    always_comb begin
        case (level_reg)
            2'd0:    begin next_bit = k_reg[1]; hold_up = hold1_reg; end
            default: begin next_bit = k_reg[2]; hold_up = hold2_reg; end
        endcase
    end

    always_comb begin
        case (level_reg)
            2'd0:    frac_sel = frac_x_reg;
            2'd1:    frac_sel = frac_y_reg;
            default: frac_sel = frac_z_reg;
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CELL: begin
                case (cnt_reg)
                    2'd0:    mul_a = MUL_A_W'(sum_x_reg);
                    2'd1:    mul_a = MUL_A_W'(sum_y_reg);
                    default: mul_a = MUL_A_W'(sum_z_reg);
                endcase
                mul_b = $signed({1'b0, inv_step_reg});
            end
            S_ADDR: begin
                case (cnt_reg)
                    2'd0: begin
                        mul_a = $signed(MUL_A_W'(side_a));
                        mul_b = $signed(MUL_B_W'(side_a));
                    end
                    2'd1: begin
                        mul_a = $signed(MUL_A_W'(side_a));
                        mul_b = $signed(MUL_B_W'(cell_y_reg[CELL_W-1:0]));
                    end
                    default: begin
                        mul_a = $signed(MUL_A_W'(s2_reg));
                        mul_b = $signed(MUL_B_W'(cell_z_reg[CELL_W-1:0]));
                    end
                endcase
            end
            S_MUL: begin
                mul_a = diff_reg;
                mul_b = $signed(MUL_B_W'(frac_sel));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Table read: corner i sits at base + i[0] + i[1]*side + i[2]*side^2
    always_comb begin
        rd_en     = 1'b0;
        rd_corner = k_reg + 3'd1;
        unique case (state_reg)
            S_FIRST: begin
                rd_en     = 1'b1;
                rd_corner = 3'd0;
            end
            S_LOAD:  rd_en = !k_reg[0];
            S_ACC:   rd_en = (level_reg != LVL_Z) && !next_bit;
            default: rd_en = 1'b0;
        endcase
    end

    assign rd_addr = base_reg + ADDR_W'(rd_corner[0]) +
                     (rd_corner[1] ? side_a : '0) +
                     (rd_corner[2] ? s2_reg : '0);

    assign wr.en   = s_fire && (s_op == OP_WRITE);
    assign wr.addr = s_entry_index;
    assign wr.data = s_entry_value;

    tgl_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    tgl_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            inv_step_reg <= STEP_W'(4096);
            side_reg     <= SIDE_W'(SIDE_MAX);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFFSET:   offset_reg   <= $signed(cfg_data[POS_W-1:0]);
                REG_INV_STEP: inv_step_reg <= cfg_data[STEP_W-1:0];
                REG_SIDE:     side_reg     <= cfg_data[SIDE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && (s_op == OP_QUERY)) begin
                        state_reg <= S_CELL;
                        cnt_reg   <= '0;
                    end
                end
                S_CELL: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    cnt_reg   <= '0;
                    state_reg <= oor ? S_OUT : S_ADDR;
                end
                S_ADDR: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    k_reg     <= '0;
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    if (!k_reg[0]) begin
                        k_reg <= k_reg + 3'd1;
                    end else begin
                        level_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_ACC;
                S_ACC: begin
                    if (level_reg == LVL_Z) begin
                        state_reg <= S_OUT;
                    end else if (!next_bit) begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_LOAD;
                    end else begin
                        level_reg <= level_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Query datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sum_x_reg <= SUM_W'(s_pos_x) + SUM_W'(offset_reg);
            sum_y_reg <= SUM_W'(s_pos_y) + SUM_W'(offset_reg);
            sum_z_reg <= SUM_W'(s_pos_z) + SUM_W'(offset_reg);
        end
        case (state_reg)
            S_CELL: begin
                // product for axis cnt-1 is in the multiplier register
                case (cnt_reg)
                    2'd1: begin cell_x_reg <= cell_new; frac_x_reg <= frac_new; end
                    2'd2: begin cell_y_reg <= cell_new; frac_y_reg <= frac_new; end
                    2'd3: begin cell_z_reg <= cell_new; frac_z_reg <= frac_new; end
                    default: ;
                endcase
            end
            S_CHECK: begin
                oor_reg <= oor;
                res_reg <= '0;
            end
            S_ADDR: begin
                case (cnt_reg)
                    2'd1: s2_reg <= prod[ADDR_W-1:0];
                    2'd2: sy_reg <= prod[ADDR_W-1:0];
                    2'd3: base_reg <= ADDR_W'(cell_x_reg[CELL_W-1:0]) + sy_reg +
                                      prod[ADDR_W-1:0];
                    default: ;
                endcase
            end
            S_LOAD: begin
                if (!k_reg[0]) begin
                    hold0_reg <= rd_data;
                end else begin
                    diff_reg  <= (SAMPLE_W+1)'(rd_data) - (SAMPLE_W+1)'(hold0_reg);
                    basev_reg <= hold0_reg;
                end
            end
            S_ACC: begin
                if (level_reg == LVL_Z) begin
                    res_reg <= lerp_r;
                end else if (!next_bit) begin
                    if (level_reg == 2'd0) begin
                        hold1_reg <= lerp_r;
                    end else begin
                        hold2_reg <= lerp_r;
                    end
                end else begin
                    diff_reg  <= (SAMPLE_W+1)'(lerp_r) - (SAMPLE_W+1)'(hold_up);
                    basev_reg <= hold_up;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_sample_reg <= res_reg;
                    m_oor_reg    <= oor_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_sample       = m_sample_reg;
    assign m_out_of_range = m_oor_reg;

    // Checks
    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_op == OP_QUERY) |=> state_reg == S_CELL)
        else $error("query accept did not start axis scaling");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_sample == '0)
        else $error("out-of-range result carries a nonzero sample");

    a_load_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOAD |-> $past(rd_en))
        else $error("corner data consumed without a read");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.en && rd_en))
        else $error("table write and read in the same cycle");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> level_reg <= LVL_Z)
        else $error("blend level past z");

endmodule
